/* design/les_pkg.sv */
// Shared types, constants and helper functions of the line edge steering unit.
`timescale 1ns / 1ps

package les_pkg;

    localparam int FRAME_ROWS_DEF = 120;
    localparam int ROW_BYTES      = 20;
    localparam int HALF_BYTES     = ROW_BYTES / 2;
    localparam int COL_W          = $clog2(ROW_BYTES);
    localparam int NUM_SLOTS      = 5;
    localparam int SLOT_W         = $clog2(NUM_SLOTS + 1);
    localparam int EDGE_W         = 8;
    localparam int WEIGHT_W       = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int STEER_W        = 9;
    localparam int DUTY_W         = 10;
    localparam int SUM_W          = 16;

    localparam int SAMPLE_ROWS [NUM_SLOTS] = '{10, 35, 60, 85, 110};

    localparam logic [EDGE_W-1:0] LEFT_NONE   = EDGE_W'(0);
    localparam logic [EDGE_W-1:0] RIGHT_NONE  = EDGE_W'(160);
    localparam logic [EDGE_W-1:0] CENTER_COL  = EDGE_W'(80);

    localparam logic [DUTY_W-1:0] DUTY_CRUISE = DUTY_W'(750);
    localparam logic [DUTY_W-1:0] DUTY_TURN   = DUTY_W'(800);
    localparam logic [DUTY_W-1:0] DUTY_LIMIT  = DUTY_W'(930);

    // Edge positions of the five sample rows of one finished frame.
    typedef struct packed {
        logic [NUM_SLOTS-1:0][EDGE_W-1:0] left;
        logic [NUM_SLOTS-1:0][EDGE_W-1:0] right;
    } t_edge_set;

    // Queue status as seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

    // Index of the lowest set bit, counted from the least significant end.
    function automatic logic [2:0] lowest_set(input logic [7:0] px);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (px[i]) begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

    // Index of the highest set bit, counted from the most significant end.
    function automatic logic [2:0] highest_set(input logic [7:0] px);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (px[i]) begin
                k = 3'(7 - i);
            end
        end
        return k;
    endfunction

endpackage

/* design/les_front.sv */
// Front part: tracks byte position and captures left and right edges of sample rows.
`timescale 1ns / 1ps

module les_front #(
    parameter int FRAME_ROWS = les_pkg::FRAME_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_pixel_byte,
    input  logic                  i_frame_start,
    input  les_pkg::t_queue_status i_qstat,
    output logic                  o_push,
    output les_pkg::t_edge_set    o_push_data
);
    import les_pkg::*;

    localparam int ROW_W = $clog2(FRAME_ROWS);

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_done, n_done;
    logic             r_right_found, n_right_found;
    logic [NUM_SLOTS-1:0][EDGE_W-1:0] r_left, n_left;
    logic [NUM_SLOTS-1:0][EDGE_W-1:0] r_right, n_right;

    logic [ROW_W-1:0] eff_row;
    logic [COL_W-1:0] eff_col;
    logic             eff_done;
    logic             accept;
    logic             active;
    logic             last_col;
    logic             last_byte;
    logic [EDGE_W-1:0] col_x8;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        eff_row   = i_frame_start ? '0 : r_row;
        eff_col   = i_frame_start ? '0 : r_col;
        eff_done  = i_frame_start ? 1'b0 : r_done;
        active    = accept && !eff_done;
        last_col  = (eff_col == COL_W'(ROW_BYTES - 1));
        last_byte = last_col && (eff_row == ROW_W'(FRAME_ROWS - 1));
        col_x8    = {eff_col, 3'b000};

        n_row         = r_row;
        n_col         = r_col;
        n_done        = r_done;
        n_right_found = r_right_found;
        n_left        = r_left;
        n_right       = r_right;

        if (accept) begin
            n_row  = eff_row;
            n_col  = eff_col;
            n_done = eff_done;
        end
        if (active) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (eff_row == ROW_W'(SAMPLE_ROWS[s])) begin
                    if (eff_col == '0) begin
                        n_left[s]     = LEFT_NONE;
                        n_right[s]    = RIGHT_NONE;
                        n_right_found = 1'b0;
                    end
                    if (i_pixel_byte != 8'd0) begin
                        if (eff_col < COL_W'(HALF_BYTES)) begin
                            n_left[s] = col_x8 + EDGE_W'(8)
                                      - EDGE_W'(lowest_set(i_pixel_byte));
                        end else if (!n_right_found) begin
                            n_right[s]    = col_x8 + EDGE_W'(1)
                                          + EDGE_W'(highest_set(i_pixel_byte));
                            n_right_found = 1'b1;
                        end
                    end
                end
            end
            if (last_byte) begin
                n_done = 1'b1;
            end else if (last_col) begin
                n_col = '0;
                n_row = eff_row + ROW_W'(1);
            end else begin
                n_col = eff_col + COL_W'(1);
            end
        end
    end

    assign o_push            = active && last_byte;
    assign o_push_data.left  = n_left;
    assign o_push_data.right = n_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row         <= '0;
            r_col         <= '0;
            r_done        <= 1'b0;
            r_right_found <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_left[s]  <= LEFT_NONE;
                r_right[s] <= RIGHT_NONE;
            end
        end else begin
            r_row         <= n_row;
            r_col         <= n_col;
            r_done        <= n_done;
            r_right_found <= n_right_found;
            r_left        <= n_left;
            r_right       <= n_right;
        end
    end

endmodule

/* design/les_queue.sv */
// Two-entry queue of finished frame edge sets between the front and back parts.
`timescale 1ns / 1ps

module les_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  les_pkg::t_edge_set     i_push_data,
    input  logic                   i_pop,
    output les_pkg::t_edge_set     o_head,
    output les_pkg::t_queue_status o_qstat
);
    import les_pkg::*;

    t_edge_set  r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_head            = r_mem[r_rd_ptr];
    assign o_qstat.full      = (r_count == 2'd2);
    assign o_qstat.not_empty = (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/les_back.sv */
// Back part: weighted deviation sum, divide by five, steering clamp and duty choice.
`timescale 1ns / 1ps

module les_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [les_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [les_pkg::WEIGHT_W-1:0]  i_cfg_data,
    input  les_pkg::t_edge_set            i_head,
    input  les_pkg::t_queue_status        i_qstat,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [les_pkg::STEER_W-1:0]   o_steer_value,
    output logic [les_pkg::DUTY_W-1:0]    o_motor_duty
);
    import les_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // Reciprocal of five scaled by 2^18; exact for magnitudes up to 2^16.
    localparam int RECIP_SHIFT = 18;
    localparam logic [15:0] RECIP5 = 16'd52429;

    logic [1:0]               r_state;
    logic [SLOT_W-1:0]        r_idx;
    logic signed [SUM_W-1:0]  r_acc;
    logic [32:0]              r_prod;
    logic                     r_neg;
    logic [NUM_SLOTS-1:0][WEIGHT_W-1:0] r_weight;
    logic                     r_out_valid;
    logic [STEER_W-1:0]       r_steer;
    logic [DUTY_W-1:0]        r_duty;

    logic [EDGE_W:0]          edge_sum;
    logic signed [EDGE_W:0]   dev;
    logic signed [SUM_W-1:0]  term;
    logic [SUM_W:0]           mag;
    logic [14:0]              quot;
    logic signed [15:0]       steer;
    logic [STEER_W-1:0]       steer_out;
    logic [DUTY_W-1:0]        duty_out;
    logic                     out_free;

    always_comb begin
        edge_sum = {1'b0, i_head.left[r_idx[2:0]]} + {1'b0, i_head.right[r_idx[2:0]]};
        dev      = $signed({1'b0, CENTER_COL}) - $signed({1'b0, edge_sum[EDGE_W:1]});
        term     = SUM_W'(dev) * SUM_W'($signed(r_weight[r_idx[2:0]]));
        mag      = r_acc[SUM_W-1] ? (SUM_W+1)'(-$signed({r_acc[SUM_W-1], r_acc}))
                                  : {1'b0, r_acc};
        quot     = r_prod[RECIP_SHIFT +: 15];
        steer    = r_neg ? (16'sd300 + $signed({1'b0, quot}))
                         : (16'sd300 - $signed({1'b0, quot}));
    end

    always_comb begin
        steer_out = steer[STEER_W-1:0];
        duty_out  = r_duty;
        if (steer < 16'sd200) begin
            steer_out = STEER_W'(200);
            duty_out  = DUTY_LIMIT;
        end else if (steer > 16'sd400) begin
            steer_out = STEER_W'(400);
            duty_out  = DUTY_LIMIT;
        end else if (steer >= 16'sd281 && steer <= 16'sd329) begin
            duty_out  = DUTY_CRUISE;
        end else if ((steer >= 16'sd230 && steer <= 16'sd280)
                  || (steer >= 16'sd330 && steer <= 16'sd380)) begin
            duty_out  = DUTY_TURN;
        end
    end

    assign out_free      = !r_out_valid || !i_stall;
    assign o_pop         = (r_state == ST_FIN) && out_free;
    assign o_valid       = r_out_valid;
    assign o_steer_value = r_steer;
    assign o_motor_duty  = r_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(NUM_SLOTS)) begin
            r_weight[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_duty      <= DUTY_CRUISE;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_qstat.not_empty) begin
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_acc <= r_acc + term;
                    if (r_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                ST_DIV: begin
                    r_prod  <= 33'(mag) * 33'(RECIP5);
                    r_neg   <= r_acc[SUM_W-1];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_steer     <= steer_out;
                        r_duty      <= duty_out;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/line_edge_steering_unit.sv */
// Top level of the line edge steering unit: front, queue and back parts.
`timescale 1ns / 1ps

// The unit takes a binary camera frame as a stream of pixel bytes, one request
// per byte, on a valid/stall channel. A frame is FRAME_ROWS rows of 20 bytes;
// a set frame-start flag marks byte zero. On five sample rows the unit keeps
// the left and right lane edges around the image center.
// The front part takes one byte per cycle unless the queue is full and does a
// small priority encode per byte, so the input sustains one request per clock.
// On the last byte of a frame the edges go into a two-entry queue. The back
// part works on one frame at a time: it starts when the queue holds a frame,
// runs a multiply-accumulate step for each of the five sample rows, then the
// divide-by-five multiply, then clamps the steering value, picks the motor
// duty, registers the result request and pops the frame from the queue.
// The output is held in a register; when the receiver stalls it, the back part
// waits, and the input stalls only once the queue holds two finished frames,
// which happens when a further frame ends while the back part still waits.
// Bytes after the end of a frame without a new frame start are taken and
// dropped. The user writes weights via the plain write port while idle; it is
// not checked. Synchronous active-low reset clears the position, the edges,
// the weights and the queue, and sets the kept motor duty to its cruise value.

module line_edge_steering_unit #(
    parameter int FRAME_ROWS = les_pkg::FRAME_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_pixel_byte,
    input  logic                          i_frame_start,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [les_pkg::STEER_W-1:0]   o_steer_value,
    output logic [les_pkg::DUTY_W-1:0]    o_motor_duty,
    input  logic                          i_cfg_we,
    input  logic [les_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [les_pkg::WEIGHT_W-1:0]  i_cfg_data
);
    import les_pkg::*;

    logic          push;
    logic          pop;
    t_edge_set     push_data;
    t_edge_set     head;
    t_queue_status qstat;

    les_front #(
        .FRAME_ROWS(FRAME_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel_byte (i_pixel_byte),
        .i_frame_start(i_frame_start),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    les_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data(push_data),
        .i_pop      (pop),
        .o_head     (head),
        .o_qstat    (qstat)
    );

    les_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_head       (head),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_steer_value(o_steer_value),
        .o_motor_duty (o_motor_duty)
    );

endmodule

/* tb/sv/steer_command_checker.sv */
// Checker for the line edge steering unit: tracks the byte stream and compares every command.
`timescale 1ns / 1ps

module steer_command_checker #(
    parameter int FRAME_ROWS = les_pkg::FRAME_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [7:0]                    i_pixel_byte,
    input  logic                          i_frame_start,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [les_pkg::STEER_W-1:0]   i_steer_value,
    input  logic [les_pkg::DUTY_W-1:0]    i_motor_duty,
    input  logic                          i_cfg_we,
    input  logic [les_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [les_pkg::WEIGHT_W-1:0]  i_cfg_data,
    output int                            o_error_count,
    output int                            o_pending
);

    import les_pkg::STEER_W;
    import les_pkg::DUTY_W;

    localparam int ROW_LEN       = 20;
    localparam int HALF_LEN      = ROW_LEN / 2;
    localparam int FRAME_LEN     = FRAME_ROWS * ROW_LEN;
    localparam int SLOTS         = 5;
    localparam int CENTER        = 80;
    localparam int NO_LEFT       = 0;
    localparam int NO_RIGHT      = 160;
    localparam int STEER_MID     = 300;
    localparam int STEER_DIV     = 5;
    localparam int STEER_FLOOR   = 200;
    localparam int STEER_CEIL    = 400;
    localparam int CRUISE_LO     = 281;
    localparam int CRUISE_HI     = 329;
    localparam int TURN_LOW_LO   = 230;
    localparam int TURN_LOW_HI   = 280;
    localparam int TURN_HIGH_LO  = 330;
    localparam int TURN_HIGH_HI  = 380;
    localparam int DUTY_CRUISE   = 750;
    localparam int DUTY_TURN     = 800;
    localparam int DUTY_LIMIT    = 930;

    typedef struct packed {
        logic [STEER_W-1:0] steer;
        logic [DUTY_W-1:0]  duty;
    } steer_cmd_t;

    steer_cmd_t        awaited_cmds[$];
    steer_cmd_t        got_cmd;
    steer_cmd_t        want_cmd;
    int                next_pos;
    int                left_col[SLOTS];
    int                right_col[SLOTS];
    bit                right_taken;
    int                kept_duty;
    logic signed [7:0] row_weight[SLOTS];
    int                mismatch_total;

    function automatic int sample_slot(input int row);
        case (row)
            10:      return 0;
            35:      return 1;
            60:      return 2;
            85:      return 3;
            110:     return 4;
            default: return -1;
        endcase
    endfunction

    task automatic clear_model();
        next_pos = 0;
        for (int s = 0; s < SLOTS; s++) begin
            left_col[s]   = NO_LEFT;
            right_col[s]  = NO_RIGHT;
            row_weight[s] = '0;
        end
        right_taken = 1'b0;
        kept_duty   = DUTY_CRUISE;
        awaited_cmds.delete();
    endtask

    // Advances the edge tracker by one byte; on the frame's last byte the
    // steering command is worked out and queued.
    task automatic track_pixel_byte(input logic [7:0] px, input logic fs);
        int         pos;
        int         col;
        int         slot;
        int         k;
        int         sum;
        int         steer;
        steer_cmd_t cmd;
        if (fs) begin
            next_pos = 0;
        end
        if (next_pos >= FRAME_LEN) begin
            return;
        end
        pos      = next_pos;
        next_pos = pos + 1;
        col      = pos % ROW_LEN;
        slot     = sample_slot(pos / ROW_LEN);
        if (slot >= 0) begin
            if (col == 0) begin
                left_col[slot]  = NO_LEFT;
                right_col[slot] = NO_RIGHT;
                right_taken     = 1'b0;
            end
            if (px != 8'h00) begin
                if (col < HALF_LEN) begin
                    // The rightmost set pixel lies closest to the center.
                    k = 0;
                    while (!px[k]) k++;
                    left_col[slot] = 8 * col + 8 - k;
                end else if (!right_taken) begin
                    k = 0;
                    while (!px[7-k]) k++;
                    right_col[slot] = 8 * col + 1 + k;
                    right_taken     = 1'b1;
                end
            end
        end
        if (pos != FRAME_LEN - 1) begin
            return;
        end
        sum = 0;
        for (int s = 0; s < SLOTS; s++) begin
            sum += (CENTER - (left_col[s] + right_col[s]) / 2) * int'(row_weight[s]);
        end
        sum   = int'($signed(sum[15:0]));
        steer = STEER_MID - sum / STEER_DIV;
        if (steer >= CRUISE_LO && steer <= CRUISE_HI) begin
            kept_duty = DUTY_CRUISE;
        end
        if ((steer >= TURN_LOW_LO && steer <= TURN_LOW_HI) ||
            (steer >= TURN_HIGH_LO && steer <= TURN_HIGH_HI)) begin
            kept_duty = DUTY_TURN;
        end
        if (steer < STEER_FLOOR) begin
            steer     = STEER_FLOOR;
            kept_duty = DUTY_LIMIT;
        end
        if (steer > STEER_CEIL) begin
            steer     = STEER_CEIL;
            kept_duty = DUTY_LIMIT;
        end
        cmd.steer = STEER_W'(steer);
        cmd.duty  = DUTY_W'(kept_duty);
        awaited_cmds.push_back(cmd);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_we && i_cfg_idx < SLOTS) begin
                row_weight[i_cfg_idx] = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                got_cmd.steer = i_steer_value;
                got_cmd.duty  = i_motor_duty;
                if (awaited_cmds.size() == 0) begin
                    $error("unexpected command: steer_value %0d motor_duty %0d",
                           got_cmd.steer, got_cmd.duty);
                    mismatch_total++;
                end else begin
                    want_cmd = awaited_cmds.pop_front();
                    if (got_cmd.steer !== want_cmd.steer) begin
                        $error("steer_value: expected %0d, actual %0d",
                               want_cmd.steer, got_cmd.steer);
                        mismatch_total++;
                    end
                    if (got_cmd.duty !== want_cmd.duty) begin
                        $error("motor_duty: expected %0d, actual %0d",
                               want_cmd.duty, got_cmd.duty);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                track_pixel_byte(i_pixel_byte, i_frame_start);
            end
        end
        o_pending     <= awaited_cmds.size();
        o_error_count <= mismatch_total;
    end

endmodule

/* tb/sv/tb_top.sv */
// Top of the line edge steering testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

// The stimulus feeds whole camera frames, one request per pixel byte, and
// lets the checker beside the unit predict and compare every steering
// command. A frame is 2400 bytes and yields exactly one command, so the
// run is built from frames rather than from single bytes: a few directed
// frames first, then several dozen random ones.
module tb_top;

    import les_pkg::*;

    localparam int FRAME_ROWS   = FRAME_ROWS_DEF;
    localparam int FRAME_LEN    = FRAME_ROWS * ROW_BYTES;
    localparam int IDLE_PCT     = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_FRAMES = 36;
    localparam int FRAMES_PER_SETTING = 3;

    // Register indexes of the write port.
    localparam int REG_WEIGHT_A     = 0;
    localparam int REG_WEIGHT_E     = 4;
    localparam int REG_UNUSED_FIRST = 5;
    localparam int REG_UNUSED_LAST  = 7;

    localparam logic [7:0] WEIGHT_MAX = 8'h7F;
    localparam logic [7:0] WEIGHT_MIN = 8'h80;

    // How the bytes of one sample row are filled.
    typedef enum int {
        ROW_BLANK,        // no set pixel: both edges stay at their defaults
        ROW_SOLID,        // every pixel set: edges meet at the center
        ROW_SPARSE,       // a few scattered pixels
        ROW_NOISE,        // random bytes
        ROW_ONLY_COL80,   // only the pixel left of the center
        ROW_ONLY_COL81,   // only the pixel right of the center
        ROW_OUTER         // only the first and the last pixel of the row
    } row_fill_e;
    localparam int ROW_FILL_COUNT = 7;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic [7:0]            i_pixel_byte  = '0;
    logic                  i_frame_start = 1'b0;
    logic                  i_stall       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [WEIGHT_W-1:0]   i_cfg_data    = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [STEER_W-1:0]    o_steer_value;
    logic [DUTY_W-1:0]     o_motor_duty;

    int mismatches;
    int pending;
    int idle_run = 0;
    // While steady is set, neither side idles.
    bit steady = 1'b0;

    line_edge_steering_unit #(
        .FRAME_ROWS(FRAME_ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_byte  (i_pixel_byte),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_steer_value (o_steer_value),
        .o_motor_duty  (o_motor_duty),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    steer_command_checker #(
        .FRAME_ROWS(FRAME_ROWS)
    ) cmd_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_pixel_byte  (i_pixel_byte),
        .i_frame_start (i_frame_start),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_steer_value (o_steer_value),
        .i_motor_duty  (o_motor_duty),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_error_count (mismatches),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver stalls the command channel at random, except in steady
    // stretches.
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // The watchdog ends the run when nothing has moved for too long: no
    // request taken, no command taken and no register written.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
            if (idle_run >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic bit is_sample_row(input int row);
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (SAMPLE_ROWS[s] == row) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] row_byte(input row_fill_e fill, input int col);
        case (fill)
            ROW_BLANK:      return 8'h00;
            ROW_SOLID:      return 8'hFF;
            ROW_SPARSE: begin
                // Mostly empty, so that the edges land all over the row.
                if ($urandom_range(0, 5) != 0) begin
                    return 8'h00;
                end else if ($urandom_range(0, 1) == 1) begin
                    return 8'h01 << $urandom_range(0, 7);
                end else begin
                    return 8'($urandom);
                end
            end
            ROW_ONLY_COL80: return (col == HALF_BYTES - 1) ? 8'h01 : 8'h00;
            ROW_ONLY_COL81: return (col == HALF_BYTES) ? 8'h80 : 8'h00;
            ROW_OUTER: begin
                if (col == 0) begin
                    return 8'h80;
                end else if (col == ROW_BYTES - 1) begin
                    return 8'h01;
                end else begin
                    return 8'h00;
                end
            end
            default:        return 8'($urandom);
        endcase
    endfunction

    // Offers one pixel byte, with random idle cycles ahead of it, and
    // returns at the clock edge that takes the request. The payload holds
    // while the unit stalls.
    task automatic send_byte(input logic [7:0] px, input logic fs);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_byte  <= px;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Sends frame bytes from_pos up to, not including, to_pos. Rows that are
    // not sampled carry random bytes. A sample row takes the given fill, or
    // a random one per row when fixed is clear.
    task automatic send_frame(input int from_pos, input int to_pos, input bit mark_start,
                              input bit fixed, input row_fill_e fill_choice);
        int        row;
        int        col;
        row_fill_e fill;
        fill = ROW_NOISE;
        for (int p = from_pos; p < to_pos; p++) begin
            row = p / ROW_BYTES;
            col = p % ROW_BYTES;
            if (col == 0 || p == from_pos) begin
                if (!is_sample_row(row)) begin
                    fill = ROW_NOISE;
                end else if (fixed) begin
                    fill = fill_choice;
                end else begin
                    fill = row_fill_e'($urandom_range(0, ROW_FILL_COUNT - 1));
                end
            end
            send_byte(row_byte(fill, col), mark_start && (p == from_pos));
        end
    endtask

    // Bytes past the end of a frame without a frame start are dropped.
    task automatic send_trailing_junk(input int count);
        for (int n = 0; n < count; n++) begin
            send_byte(8'($urandom), 1'b0);
        end
    endtask

    // Waits until every predicted command has come back, then lets the
    // back part finish whatever it still holds.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Raises a write for one cycle. The caller lowers the write enable once
    // its last write has gone through.
    task automatic write_reg(input int idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic write_weights(input logic [NUM_SLOTS-1:0][7:0] w);
        for (int r = REG_WEIGHT_A; r <= REG_WEIGHT_E; r++) begin
            write_reg(r, w[r - REG_WEIGHT_A]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Small weights keep the steering value spread over all duty bands;
    // full-range ones drive it into the clamps.
    function automatic logic [NUM_SLOTS-1:0][7:0] random_weights();
        logic [NUM_SLOTS-1:0][7:0] w;
        int                        pick;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                w[s] = 8'($urandom_range(0, 16) - 8);
            end else if (pick < 9) begin
                w[s] = 8'($urandom);
            end else begin
                w[s] = 8'h00;
            end
        end
        return w;
    endfunction

    initial begin
        int cut;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Right after reset the first byte counts as byte zero even without
        // a frame start. Weights are still zero, so the command is straight.
        send_frame(0, FRAME_LEN, 1'b0, 1'b0, ROW_NOISE);
        send_trailing_junk(5);

        // With all weights at the top of their range, a lone pixel right of
        // the center clamps low and a lone pixel left of it clamps high.
        wait_idle();
        write_weights({NUM_SLOTS{WEIGHT_MAX}});
        send_frame(0, FRAME_LEN, 1'b1, 1'b1, ROW_ONLY_COL81);
        send_frame(0, FRAME_LEN, 1'b1, 1'b1, ROW_ONLY_COL80);
        send_frame(0, FRAME_LEN, 1'b1, 1'b1, ROW_SOLID);
        send_frame(0, FRAME_LEN, 1'b1, 1'b1, ROW_BLANK);
        send_frame(0, FRAME_LEN, 1'b1, 1'b1, ROW_OUTER);

        // The most negative weights mirror the clamps.
        wait_idle();
        write_weights({NUM_SLOTS{WEIGHT_MIN}});
        send_frame(0, FRAME_LEN, 1'b1, 1'b1, ROW_ONLY_COL81);
        send_frame(0, FRAME_LEN, 1'b1, 1'b1, ROW_ONLY_COL80);

        // A write to an index past the last weight must change nothing.
        wait_idle();
        write_reg($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST), 8'($urandom));
        write_weights({8'h00, 8'hFF, 8'h01, WEIGHT_MIN, WEIGHT_MAX});
        send_frame(0, FRAME_LEN, 1'b1, 1'b0, ROW_NOISE);

        for (int f = 0; f < RANDOM_FRAMES; f++) begin
            if (f % FRAMES_PER_SETTING == 0) begin
                wait_idle();
                write_weights(random_weights());
            end
            // Every few frames one runs with no idling on either side.
            steady <= (f % 7 == 3);
            case ($urandom_range(0, 9))
                0: begin
                    // A frame cut short by a new frame start.
                    cut = $urandom_range(1, FRAME_LEN - 1);
                    send_frame(0, cut, 1'b1, 1'b0, ROW_NOISE);
                    send_frame(0, FRAME_LEN, 1'b1, 1'b0, ROW_NOISE);
                end
                1: begin
                    // A frame whose second part carries no frame start.
                    cut = $urandom_range(1, FRAME_LEN - 1);
                    send_frame(0, cut, 1'b1, 1'b0, ROW_NOISE);
                    send_frame(cut, FRAME_LEN, 1'b0, 1'b0, ROW_NOISE);
                end
                2: begin
                    send_frame(0, FRAME_LEN, 1'b1, 1'b1,
                               row_fill_e'($urandom_range(0, ROW_FILL_COUNT - 1)));
                end
                default: begin
                    send_frame(0, FRAME_LEN, 1'b1, 1'b0, ROW_NOISE);
                end
            endcase
            if ($urandom_range(0, 7) == 0) begin
                send_trailing_junk($urandom_range(1, 30));
            end
        end

        steady <= 1'b0;
        wait_idle();
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
